// File: hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Table depth, field widths, action codes and the cell control and status structs.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 5;
  localparam int ACT_W    = 2;
  localparam int OUT_W    = 80;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  typedef logic [DATA_W-1:0] data_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic  insert_en;
    logic  remove_en;
    data_t value;
  } cell_ctl_t;

  // compare status of one cell
  typedef struct packed {
    logic less;
    logic hit;
  } cell_stat_t;

endpackage

// File: hdl/sorted_list_engine.sv
// An accepted transaction is registered, then loaded into the result register.
// Throughput: one transaction per cycle unless the output stalls; the cell row
// updates in the accept cycle. Reset empties the table (count 0), not the slots.
// ----------------------------------------------------------------------------
// sorted_list_engine: sorted table with insert, remove, search and clear
// A row of compare-and-shift cells keeps the values in order; a result
// register reports position, count, first and last value and flags.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // value[31:0]
  input  logic [ACT_W-1:0] s_axis_tuser_i,   // action[1:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o    // position[4:0], count[9:5],
                                             // first_value[41:10],
                                             // last_value[73:42],
                                             // is_empty[74], error[75]
);

  logic             accept, advance, take;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             err_q, err_d;
  logic             found, full;
  logic [CNT_W-1:0] hit_pos;
  cell_ctl_t        ctl;
  cell_stat_t       stat [CAPACITY];
  data_t            vals [CAPACITY];

  assign advance         = pend_q && take;
  assign s_axis_tready_o = !pend_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    found   = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found   = found | stat[i].hit;
      hit_pos = hit_pos | (stat[i].hit ? CNT_W'(i + 1) : '0);
    end
  end

  assign ctl.value     = s_axis_tdata_i;
  assign ctl.insert_en = accept && (s_axis_tuser_i == ACT_INSERT) && !full;
  assign ctl.remove_en = accept && (s_axis_tuser_i == ACT_REMOVE) && found;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sle_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (CNT_W'(g) < count_q),
      .left_less_i ((g == 0) ? 1'b1 : stat[(g == 0) ? 0 : g - 1].less),
      .left_val_i  (vals[(g == 0) ? 0 : g - 1]),
      .right_val_i (vals[(g == CAPACITY - 1) ? g : g + 1]),
      .val_o       (vals[g]),
      .stat_o      (stat[g])
    );
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    err_d   = err_q;
    pend_d  = pend_q;
    if (advance) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
      pos_d  = '0;
      err_d  = 1'b0;
      case (s_axis_tuser_i)
        ACT_INSERT: begin
          if (full) begin
            err_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (found) begin
            count_d = count_q - CNT_W'(1);
          end else begin
            err_d = 1'b1;
          end
        end
        ACT_SEARCH: begin
          pos_d = hit_pos;
        end
        ACT_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    err_q <= err_d;
  end

  sle_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .take_o          (take),
    .pos_i           (pos_q),
    .err_i           (err_q),
    .count_i         (count_q),
    .vals_i          (vals),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// File: hdl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted table
// Compares its entry with the broadcast key and shifts right on insert or
// left on remove, taking data from its neighbor.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic       valid_i,      // slot index below the entry count
  input  logic       left_less_i,  // left neighbor holds a value below the key
  input  data_t      left_val_i,
  input  data_t      right_val_i,
  output data_t      val_o,
  output cell_stat_t stat_o
);

  data_t val_q, val_d;
  logic  less;

  assign less        = valid_i && ($signed(val_q) < $signed(ctl_i.value));
  assign stat_o.less = less;
  // first slot not below the key, and equal to it
  assign stat_o.hit  = valid_i && !less && left_less_i && (val_q == ctl_i.value);
  assign val_o       = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert_en && !less) begin
      val_d = left_less_i ? ctl_i.value : left_val_i;
    end else if (ctl_i.remove_en && !less) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: hdl/sle_result.sv
// ----------------------------------------------------------------------------
// sle_result: result register of the sorted list engine
// Builds the result from the table state and holds it until taken.
// ----------------------------------------------------------------------------
module sle_result
  import sle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  output logic             take_o,
  input  logic [CNT_W-1:0] pos_i,
  input  logic             err_i,
  input  logic [CNT_W-1:0] count_i,
  input  data_t            vals_i [CAPACITY],
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  logic             valid_q, valid_d;
  logic [OUT_W-1:0] data_q;
  logic [CNT_W-1:0] last_idx;
  logic             empty;
  data_t            first_val, last_val;

  assign take_o   = !valid_q || m_axis_tready_i;
  assign empty    = (count_i == '0);
  assign last_idx = count_i - CNT_W'(1);
  assign first_val = empty ? '0 : vals_i[0];
  assign last_val  = empty ? '0 : vals_i[last_idx[IDX_W-1:0]];

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {4'b0, err_i, empty, last_val, first_val,
                 POS_W'(count_i), POS_W'(pos_i)};
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// File: hdl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_assertions: port-level checks of the sorted list engine
// Watches the result stream for consistent status fields.
// ----------------------------------------------------------------------------
module sle_assertions
  import sle_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [OUT_W-1:0]  m_axis_tdata_o
);

  logic [4:0]  cnt;
  logic [31:0] first_v, last_v;
  logic        empty;

  assign cnt     = m_axis_tdata_o[9:5];
  assign first_v = m_axis_tdata_o[41:10];
  assign last_v  = m_axis_tdata_o[73:42];
  assign empty   = m_axis_tdata_o[74];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (empty == (cnt == 5'd0)))
    else $error("empty flag disagrees with count");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && empty |-> (first_v == 32'd0) && (last_v == 32'd0))
    else $error("empty table reports values");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (cnt == 5'd1) |-> (first_v == last_v))
    else $error("single entry with differing first and last");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !empty |-> !($signed(last_v) < $signed(first_v)))
    else $error("table out of order");

endmodule

bind sorted_list_engine sle_assertions u_sle_assertions (.*);

// File: verif/sle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sle_checker: result checker for the sorted list engine
// Watches both stream channels, keeps a shadow sorted table, predicts the
// result of every accepted action and compares it with the result returned.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [DATA_W-1:0] s_axis_tdata_i,   // value[31:0]
  input  logic [ACT_W-1:0]  s_axis_tuser_i,   // action[1:0]
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [OUT_W-1:0]  m_axis_tdata_i,   // position[4:0], count[9:5],
                                              // first_value[41:10],
                                              // last_value[73:42],
                                              // is_empty[74], error[75]
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o,
  output int                found_o,
  output int                rejected_o
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
    data_t            first_value;
    data_t            last_value;
    logic             is_empty;
    logic             error;
  } list_result_t;

  data_t        slots [CAPACITY];
  int           slot_count = 0;
  list_result_t expected_results [$];
  list_result_t want;
  list_result_t got;
  int           mismatch_cnt = 0;
  int           checked_cnt  = 0;
  int           found_cnt    = 0;
  int           rejected_cnt = 0;

  // apply one action to the shadow table and return the result it must give
  function automatic list_result_t apply_action(logic [ACT_W-1:0] act, data_t v);
    list_result_t r;
    int           lb;
    int           k;
    r  = '0;
    lb = 0;
    while (lb < slot_count && $signed(slots[lb]) < $signed(v)) lb++;
    case (act)
      ACT_INSERT: begin
        if (slot_count >= CAPACITY) begin
          r.error = 1'b1;
        end else begin
          for (k = slot_count; k > lb; k--) slots[k] = slots[k-1];
          slots[lb] = v;
          slot_count++;
        end
      end
      ACT_REMOVE: begin
        if (lb < slot_count && slots[lb] == v) begin
          for (k = lb; k + 1 < slot_count; k++) slots[k] = slots[k+1];
          slot_count--;
        end else begin
          r.error = 1'b1;
        end
      end
      ACT_SEARCH: begin
        if (lb < slot_count && slots[lb] == v) r.position = POS_W'(lb + 1);
      end
      default: begin
        slot_count = 0;
      end
    endcase
    r.count = POS_W'(slot_count);
    if (slot_count == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.first_value = slots[0];
      r.last_value  = slots[slot_count-1];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v,
                             logic [DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h",
               $realtime, name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results come back in order, so retire the oldest prediction first
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.position    = m_axis_tdata_i[4:0];
        got.count       = m_axis_tdata_i[9:5];
        got.first_value = m_axis_tdata_i[41:10];
        got.last_value  = m_axis_tdata_i[73:42];
        got.is_empty    = m_axis_tdata_i[74];
        got.error       = m_axis_tdata_i[75];
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual 0x%h",
                   $realtime, m_axis_tdata_i);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("position", DATA_W'(want.position), DATA_W'(got.position));
          check_field("count", DATA_W'(want.count), DATA_W'(got.count));
          check_field("first_value", want.first_value, got.first_value);
          check_field("last_value", want.last_value, got.last_value);
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
          check_field("error", DATA_W'(want.error), DATA_W'(got.error));
          checked_cnt++;
          if (want.position != 0) found_cnt++;
          if (want.error) rejected_cnt++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(apply_action(s_axis_tuser_i, s_axis_tdata_i));
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= expected_results.size();
    checked_o    <= checked_cnt;
    found_o      <= found_cnt;
    rejected_o   <= rejected_cnt;
  end

endmodule

// File: verif/sorted_list_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_engine_test: testbench top of the sorted list engine
// Drives directed and random insert, remove, search and clear transactions
// with random stalls on both sides; a checker instance predicts and compares.
// ----------------------------------------------------------------------------
module sorted_list_engine_test;
  import sle_pkg::*;

  localparam int RANDOM_ITEMS = 1420;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 23;

  typedef enum logic [1:0] {GROW, SHRINK, MIXED} traffic_mode_e;

  logic              clk;
  logic              rst_n   = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  data_t             s_value = '0;
  logic [ACT_W-1:0]  s_action = ACT_INSERT;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [OUT_W-1:0]  m_data;

  int    mismatches;
  int    pending;
  int    checked;
  int    found;
  int    rejected;
  int    cycle_cnt = 0;
  int    sent_cnt  = 0;
  int    directed_cnt;
  bit    steady    = 1'b0;
  data_t recent_vals [$];

  sorted_list_engine i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_value),
    .s_axis_tuser_i  (s_action),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  sle_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_value),
    .s_axis_tuser_i  (s_action),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .found_o         (found),
    .rejected_o      (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_cnt, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_action(input logic [ACT_W-1:0] act, input data_t v);
    s_valid  <= 1'b1;
    s_action <= act;
    s_value  <= v;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_cnt++;
    if (act == ACT_INSERT) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endtask

  task automatic idle_gaps();
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // mix small values, extremes, recently inserted values and full-range noise
  function automatic data_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) begin
      return data_t'(int'($urandom_range(8)) - 4);
    end else if (r < 45) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0001;
        default: return 32'h7fff_fffe;
      endcase
    end else if (r < 65 && recent_vals.size() > 0) begin
      return recent_vals[$urandom_range(recent_vals.size() - 1)];
    end
    return data_t'($urandom);
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(traffic_mode_e mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      GROW: begin
        if (r < 65) return ACT_INSERT;
        if (r < 80) return ACT_REMOVE;
        if (r < 98) return ACT_SEARCH;
      end
      SHRINK: begin
        if (r < 20) return ACT_INSERT;
        if (r < 75) return ACT_REMOVE;
        if (r < 98) return ACT_SEARCH;
      end
      default: begin
        if (r < 40) return ACT_INSERT;
        if (r < 65) return ACT_REMOVE;
        if (r < 97) return ACT_SEARCH;
      end
    endcase
    return ACT_CLEAR;
  endfunction

  initial begin
    traffic_mode_e mode;
    mode = MIXED;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: search miss, remove of absent value, clear
    send_action(ACT_SEARCH, 32'd0);
    send_action(ACT_REMOVE, 32'd0);
    send_action(ACT_CLEAR, 32'd0);
    send_action(ACT_INSERT, 32'h7fff_ffff);
    send_action(ACT_INSERT, 32'h8000_0000);
    send_action(ACT_INSERT, 32'd0);
    send_action(ACT_INSERT, 32'd5);
    send_action(ACT_INSERT, 32'd5);
    send_action(ACT_INSERT, 32'hffff_ffff);
    // first of two equal entries
    send_action(ACT_SEARCH, 32'd5);
    send_action(ACT_SEARCH, 32'd7);
    send_action(ACT_REMOVE, 32'd5);
    send_action(ACT_REMOVE, 32'd7);
    send_action(ACT_SEARCH, 32'h8000_0000);
    send_action(ACT_SEARCH, 32'h7fff_ffff);
    // five entries left: fill the table, then overflow it
    repeat (CAPACITY - 5) send_action(ACT_INSERT, data_t'($urandom));
    send_action(ACT_INSERT, 32'd1);
    send_action(ACT_CLEAR, 32'hffff_ffff);
    directed_cnt = sent_cnt;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mode = traffic_mode_e'($urandom_range(2));
      steady = (n >= 600 && n < 900);
      if (n == 300 || n == 1100) begin
        // hold off until every outstanding result has drained
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      idle_gaps();
      send_action(pick_action(mode), pick_value());
    end
    steady = 1'b0;

    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d transactions (%0d directed), checked %0d results,",
             sent_cnt, directed_cnt, checked);
    $display("including %0d search hits and %0d rejected inserts or removes.",
             found, rejected);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sle_result.sv
hdl/sorted_list_engine.sv
hdl/sle_checker.sv
verif/sle_checker.sv
verif/sorted_list_engine_test.sv
